[design/assert_macros.svh]
// Assertion macros shared by the state-space block.
// Used by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sss_pkg.sv]
// Shared constants, codes and types of the state-space system block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sss_pkg;

    // Default configuration of the block.
    localparam int SSS_MAX_ORDER      = 4;
    localparam int SSS_COEF_FRAC_BITS = 14;

    // Fixed formats of the data path.
    localparam int SSS_STATE_FRAC_BITS = 8;
    localparam int SSS_COEF_W          = 18;
    localparam int SSS_STATE_W         = 32;
    localparam int SSS_SAMPLE_W        = 16;
    localparam int SSS_ORDER_W         = 3;

    // Row and column tags cover any order the order register selects.
    localparam int SSS_ROW_W = 3;

    // Cycles from issuing the last product until its result is stored.
    localparam int SSS_PIPE_LAT = 4;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] SSS_OP_SAMPLE = 2'd0;
    localparam logic [1:0] SSS_OP_COEF   = 2'd1;
    localparam logic [1:0] SSS_OP_CLEAR  = 2'd2;

    // Configuration register map (index is paddr[2]).
    localparam int         SSS_PADDR_W   = 3;
    localparam logic       SSS_REG_ORDER = 1'b0;
    localparam logic [2:0] SSS_ORDER_RST = 3'd1;

    // One product term travelling down the multiply-accumulate pipeline.
    typedef struct packed {
        logic                 vld;
        logic                 first;
        logic                 last;
        logic                 is_y;
        logic                 use_u;
        logic [SSS_ROW_W-1:0] row;
        logic [SSS_ROW_W-1:0] xsel;
    } sss_tag_t;

    // One finished, rounded and saturated sum.
    typedef struct packed {
        logic                   vld;
        logic                   is_y;
        logic                   clip;
        logic [SSS_ROW_W-1:0]   row;
        logic [SSS_STATE_W-1:0] value;
    } sss_res_t;

endpackage

[design/sss_seq.sv]
// Term sequencer: walks the product terms of one sample through the shared
// multiply-accumulate unit and waits for the pipeline to drain. Uses sss_pkg.
`timescale 1ns / 1ps

module sss_seq #(
    parameter int MAX_ORDER = sss_pkg::SSS_MAX_ORDER,
    parameter int N_W       = 3,
    parameter int COEF_AW   = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [N_W-1:0]        n_in,
    input  logic                  out_free,
    output logic                  busy,
    output logic                  done,
    output logic [COEF_AW-1:0]    coef_addr,
    output sss_pkg::sss_tag_t     tag
);
    import sss_pkg::*;

    localparam int B_BASE = MAX_ORDER * MAX_ORDER;
    localparam int C_BASE = MAX_ORDER * MAX_ORDER + MAX_ORDER;
    localparam int D_SLOT = MAX_ORDER * MAX_ORDER + 2 * MAX_ORDER;
    localparam int DR_W   = $clog2(SSS_PIPE_LAT + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [N_W-1:0]     pass_reg, pass_next;
    logic [N_W-1:0]     col_reg, col_next;
    logic [COEF_AW-1:0] abase_reg, abase_next;
    logic [DR_W-1:0]    drain_reg, drain_next;

    // Pass zero forms the output, pass p forms new state element p-1.
    // Column zero is the input term, column c the term of state element c-1.
    always_comb begin
        if (pass_reg == '0) begin
            if (col_reg == '0) begin
                coef_addr = COEF_AW'(D_SLOT);
            end else begin
                coef_addr = COEF_AW'(C_BASE - 1) + COEF_AW'(col_reg);
            end
        end else begin
            if (col_reg == '0) begin
                coef_addr = COEF_AW'(B_BASE - 1) + COEF_AW'(pass_reg);
            end else begin
                coef_addr = abase_reg + COEF_AW'(col_reg) - COEF_AW'(1);
            end
        end
    end

    // Sequencer next state and term issue.
    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        col_next   = col_reg;
        abase_next = abase_reg;
        drain_next = drain_reg;
        done       = 1'b0;
        tag        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    pass_next  = '0;
                    col_next   = '0;
                    abase_next = '0;
                end
            end
            ST_RUN: begin
                tag.vld   = 1'b1;
                tag.first = (col_reg == '0);
                tag.last  = (col_reg == n_in);
                tag.is_y  = (pass_reg == '0);
                tag.use_u = (col_reg == '0);
                tag.row   = SSS_ROW_W'(pass_reg - N_W'(1));
                tag.xsel  = SSS_ROW_W'(col_reg - N_W'(1));
                if (col_reg == n_in) begin
                    col_next = '0;
                    if (pass_reg == n_in) begin
                        state_next = ST_DRAIN;
                        drain_next = DR_W'(SSS_PIPE_LAT);
                    end else begin
                        pass_next = pass_reg + N_W'(1);
                        if (pass_reg == '0) begin
                            abase_next = '0;
                        end else begin
                            abase_next = abase_reg + COEF_AW'(MAX_ORDER);
                        end
                    end
                end else begin
                    col_next = col_reg + N_W'(1);
                end
            end
            ST_DRAIN: begin
                if (drain_reg != '0) begin
                    drain_next = drain_reg - DR_W'(1);
                end else if (out_free) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= '0;
            col_reg   <= '0;
            abase_reg <= '0;
            drain_reg <= '0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            col_reg   <= col_next;
            abase_reg <= abase_next;
            drain_reg <= drain_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[design/sss_mac.sv]
// Shared multiply-accumulate unit with round-to-nearest and saturation of
// each finished sum. Uses sss_pkg for formats and the tag and result types.
`timescale 1ns / 1ps

module sss_mac #(
    parameter int MAX_ORDER      = sss_pkg::SSS_MAX_ORDER,
    parameter int COEF_FRAC_BITS = sss_pkg::SSS_COEF_FRAC_BITS
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic signed [sss_pkg::SSS_COEF_W-1:0]      coef_in,
    input  logic signed [sss_pkg::SSS_STATE_W-1:0]     opnd_in,
    input  sss_pkg::sss_tag_t                          tag_in,
    output sss_pkg::sss_res_t                          res
);
    import sss_pkg::*;

    localparam int PROD_W = SSS_COEF_W + SSS_STATE_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_ORDER + 1);
    localparam int SHIFT_X = COEF_FRAC_BITS;
    localparam int SHIFT_Y = COEF_FRAC_BITS + SSS_STATE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF_X = ACC_W'(1) << (SHIFT_X - 1);
    localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) << (SHIFT_Y - 1);

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    sss_tag_t                 tag2_reg, tag3_reg;
    sss_res_t                 res_reg, res_next;

    logic signed [ACC_W-1:0]  half;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  sh_x;
    logic signed [ACC_W-1:0]  sh_y;
    logic                     fit_x;
    logic                     fit_y;
    logic [SSS_STATE_W-1:0]   val_x;
    logic [SSS_SAMPLE_W-1:0]  val_y;

    // Product of one coefficient and one state-unit operand.
    assign prod_next = coef_in * opnd_in;

    // Accumulate: the first term of a sum restarts the accumulator.
    assign acc_next = tag2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    // Round by adding half an output unit, then floor through the shift.
    assign half = tag3_reg.is_y ? HALF_Y : HALF_X;
    assign sum  = acc_reg + half;
    assign sh_x = sum >>> SHIFT_X;
    assign sh_y = sum >>> SHIFT_Y;

    // A value fits when all bits above the target sign bit match it.
    assign fit_x = (&sh_x[ACC_W-1:SSS_STATE_W-1]) | ~(|sh_x[ACC_W-1:SSS_STATE_W-1]);
    assign fit_y = (&sh_y[ACC_W-1:SSS_SAMPLE_W-1]) | ~(|sh_y[ACC_W-1:SSS_SAMPLE_W-1]);

    always_comb begin
        if (fit_x) begin
            val_x = sh_x[SSS_STATE_W-1:0];
        end else begin
            val_x = sh_x[ACC_W-1] ? {1'b1, {(SSS_STATE_W-1){1'b0}}}
                                  : {1'b0, {(SSS_STATE_W-1){1'b1}}};
        end
        if (fit_y) begin
            val_y = sh_y[SSS_SAMPLE_W-1:0];
        end else begin
            val_y = sh_y[ACC_W-1] ? {1'b1, {(SSS_SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SSS_SAMPLE_W-1){1'b1}}};
        end
    end

    // Finished sum leaves on the cycle after its last term is accumulated.
    always_comb begin
        res_next.vld  = tag3_reg.vld & tag3_reg.last;
        res_next.is_y = tag3_reg.is_y;
        res_next.row  = tag3_reg.row;
        if (tag3_reg.is_y) begin
            res_next.clip  = ~fit_y;
            res_next.value = {{(SSS_STATE_W-SSS_SAMPLE_W){val_y[SSS_SAMPLE_W-1]}}, val_y};
        end else begin
            res_next.clip  = ~fit_x;
            res_next.value = val_x;
        end
    end

    // Pipeline registers: product, accumulator, result.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (tag2_reg.vld) begin
            acc_reg <= acc_next;
        end
        if (!aresetn) begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            res_reg  <= '0;
        end else begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[design/state_space_system_step.sv]
// Discrete SISO state-space system: a sample transfer returns y = C.x + D.u
// from the old state and then loads x = A.x + B.u, all products formed by
// one shared 18x32 multiply-accumulate unit fed one term per cycle. A sample
// occupies the block from its accept cycle until it can accept again: the
// accept cycle, its term issues, the drain of that unit's pipeline and the
// commit of the state; the commit also waits while an earlier result is still
// untaken. Coefficient and clear transfers do not occupy the block.
// Coefficients reset to zero through per-entry valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module state_space_system_step #(
    parameter int MAX_ORDER      = sss_pkg::SSS_MAX_ORDER,
    parameter int COEF_FRAC_BITS = sss_pkg::SSS_COEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] sample_in, [23:16] coef_index, [41:24] coef_value, [47:42] zero
    input  logic [47:0]                     s_axis_tdata,
    // [1:0] op
    input  logic [1:0]                      s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] sample_out
    output logic [15:0]                     m_axis_tdata,
    // [0] saturated
    output logic [0:0]                      m_axis_tuser,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sss_pkg::SSS_PADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import sss_pkg::*;

    localparam int COEF_COUNT = MAX_ORDER * MAX_ORDER + 2 * MAX_ORDER + 1;
    localparam int COEF_AW    = $clog2(COEF_COUNT);
    localparam int N_W        = $clog2(MAX_ORDER + 1);
    localparam int X_W        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam logic [3:0] MAX_N = 4'(MAX_ORDER);

    // Input field split.
    logic signed [SSS_SAMPLE_W-1:0] in_sample;
    logic [7:0]                     in_index;
    logic signed [SSS_COEF_W-1:0]   in_coef;
    logic [1:0]                     in_op;
    logic                           in_xfer;
    logic                           start;

    // Configuration.
    logic [SSS_ORDER_W-1:0] order_reg;
    logic [3:0]             ord4;
    logic [3:0]             n4;
    logic [N_W-1:0]         n_reg;

    // Coefficient memory with per-entry valid bits.
    logic [SSS_COEF_W-1:0] coef_mem [COEF_COUNT];
    logic [COEF_COUNT-1:0] coef_vld_reg;
    logic [SSS_COEF_W-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic                  coef_wr;

    // State vector, next-state buffer and output staging.
    logic signed [SSS_STATE_W-1:0]  state_reg [MAX_ORDER];
    logic [SSS_STATE_W-1:0]         nbuf_reg [MAX_ORDER];
    logic [SSS_SAMPLE_W-1:0]        y_reg;
    logic                           sat_reg;
    logic signed [SSS_SAMPLE_W-1:0] u_reg;

    // Operand stage feeding the shared unit.
    logic signed [SSS_STATE_W-1:0] opnd_reg;
    logic signed [SSS_STATE_W-1:0] opnd_next;
    logic signed [SSS_COEF_W-1:0]  coef_op;
    sss_tag_t                      tag1_reg;

    // Sequencer and unit connections.
    logic               seq_busy;
    logic               seq_done;
    logic               out_free;
    logic [COEF_AW-1:0] coef_addr;
    sss_tag_t           iss_tag;
    sss_res_t           mac_res;

    // Output register.
    logic                    m_valid_reg;
    logic [SSS_SAMPLE_W-1:0] m_data_reg;
    logic                    m_sat_reg;

    assign in_sample = s_axis_tdata[15:0];
    assign in_index  = s_axis_tdata[23:16];
    assign in_coef   = s_axis_tdata[41:24];
    assign in_op     = s_axis_tuser;

    assign s_axis_tready = ~seq_busy;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign start         = in_xfer & (in_op == SSS_OP_SAMPLE);
    assign coef_wr       = in_xfer & (in_op == SSS_OP_COEF) && (in_index < 8'(COEF_COUNT));
    assign out_free      = ~m_valid_reg | m_axis_tready;

    // Configuration register write and read-back.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == SSS_REG_ORDER) ? {{(32-SSS_ORDER_W){1'b0}}, order_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= SSS_ORDER_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == SSS_REG_ORDER)) begin
            order_reg <= pwdata[SSS_ORDER_W-1:0];
        end
    end

    // Order in use: zero counts as one, anything above the maximum as the maximum.
    assign ord4 = {1'b0, order_reg};
    always_comb begin
        if (ord4 == 4'd0) begin
            n4 = 4'd1;
        end else if (ord4 > MAX_N) begin
            n4 = MAX_N;
        end else begin
            n4 = ord4;
        end
    end

    // Coefficient memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (coef_wr) begin
            coef_mem[in_index[COEF_AW-1:0]] <= in_coef;
        end
        rd_data_reg <= coef_mem[coef_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            if (coef_wr) begin
                coef_vld_reg[in_index[COEF_AW-1:0]] <= 1'b1;
            end
            rd_vld_reg <= coef_vld_reg[coef_addr];
        end
    end

    // A never-written coefficient reads as zero.
    assign coef_op = rd_vld_reg ? rd_data_reg : '0;

    // Operand select: the input in state units, or one old state element.
    always_comb begin
        if (iss_tag.use_u) begin
            opnd_next = {{(SSS_STATE_W-SSS_SAMPLE_W-SSS_STATE_FRAC_BITS){u_reg[SSS_SAMPLE_W-1]}},
                         u_reg, {SSS_STATE_FRAC_BITS{1'b0}}};
        end else begin
            opnd_next = state_reg[iss_tag.xsel[X_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        opnd_reg <= opnd_next;
        if (start) begin
            u_reg <= in_sample;
            n_reg <= n4[N_W-1:0];
        end
        if (!aresetn) begin
            tag1_reg <= '0;
        end else begin
            tag1_reg <= iss_tag;
        end
    end

    sss_seq #(
        .MAX_ORDER (MAX_ORDER),
        .N_W       (N_W),
        .COEF_AW   (COEF_AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .n_in      (n_reg),
        .out_free  (out_free),
        .busy      (seq_busy),
        .done      (seq_done),
        .coef_addr (coef_addr),
        .tag       (iss_tag)
    );

    sss_mac #(
        .MAX_ORDER      (MAX_ORDER),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef_in (coef_op),
        .opnd_in (opnd_reg),
        .tag_in  (tag1_reg),
        .res     (mac_res)
    );

    // Collect finished sums; the saturation flag gathers over the sample.
    always_ff @(posedge aclk) begin
        if (mac_res.vld) begin
            if (mac_res.is_y) begin
                y_reg <= mac_res.value[SSS_SAMPLE_W-1:0];
            end else begin
                nbuf_reg[mac_res.row[X_W-1:0]] <= mac_res.value;
            end
        end
        if (start) begin
            sat_reg <= 1'b0;
        end else if (mac_res.vld && mac_res.clip) begin
            sat_reg <= 1'b1;
        end
    end

    // State vector: cleared by a clear transfer, committed when a sample ends.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ORDER; i++) begin
            if (!aresetn) begin
                state_reg[i] <= '0;
            end else if (in_xfer && (in_op == SSS_OP_CLEAR)) begin
                state_reg[i] <= '0;
            end else if (seq_done && (i < int'(n_reg))) begin
                state_reg[i] <= nbuf_reg[i];
            end
        end
    end

    // Output register, loaded only when the previous result has gone.
    always_ff @(posedge aclk) begin
        if (seq_done) begin
            m_data_reg <= y_reg;
            m_sat_reg  <= sat_reg;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_sat_reg;

    // A finished sample never overwrites a result that is still waiting.
    `ASSERT_IMPLIES(a_done_free, aclk, aresetn, seq_done, (!m_valid_reg || m_axis_tready),
        "sample finished while output register held an untaken result")
    // Sums only come out of the unit while a sample is in progress.
    `ASSERT_IMPLIES(a_res_busy, aclk, aresetn, mac_res.vld, seq_busy,
        "multiply-accumulate result arrived while sequencer was idle")
    // An accepted sample closes the input on the next cycle.
    `ASSERT_NEXT(a_start_busy, aclk, aresetn, start, (seq_busy && !s_axis_tready),
        "accepted sample did not start the sequencer")
    // A finished sample presents its result on the next cycle.
    `ASSERT_NEXT(a_done_out, aclk, aresetn, seq_done, m_axis_tvalid,
        "finished sample did not present a result")

endmodule

[tb/tb.sv]
// Self-checking testbench for the discrete state-space system block.
// Depends on sss_pkg and state_space_system_step; drives its streams and register port.
`timescale 1ns / 1ps

module tb;
    import sss_pkg::*;

    // Op code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Extremes of a Q4.14 coefficient and of an input sample.
    localparam logic [17:0] COEF_MAX = 18'h1FFFF;
    localparam logic [17:0] COEF_MIN = 18'h20000;
    localparam logic [17:0] COEF_ONE = 18'd16384;
    localparam logic [15:0] U_MAX    = 16'h7FFF;
    localparam logic [15:0] U_MIN    = 16'h8000;

    // The settle wait outlasts a sample, from one accepted transfer to the next.
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 60;

    // Order written at the start of each random phase, out-of-range codes included.
    localparam int ORDER_PLAN [8] = '{4, 1, 2, 3, 0, 7, 5, 4};

    // Tracks coefficients, state and order, and predicts y(k) for every sample.
    class ss_tracker;
        localparam int NX      = SSS_MAX_ORDER;
        localparam int NCOEF   = NX * NX + 2 * NX + 1;
        localparam int B_BASE  = NX * NX;
        localparam int C_BASE  = NX * NX + NX;
        localparam int D_SLOT  = NX * NX + 2 * NX;
        localparam int X_SHIFT = SSS_COEF_FRAC_BITS;
        localparam int Y_SHIFT = SSS_COEF_FRAC_BITS + SSS_STATE_FRAC_BITS;

        typedef struct {
            logic [15:0] y;
            logic        sat;
        } y_exp_t;

        int         x_vec [NX];
        int         coefs [NCOEF];
        logic [2:0] order_sel;
        y_exp_t     expected_y [$];
        int         errors, n_samples, n_coefs, n_clears, n_ignored, n_applied;
        int         n_results, n_clipped;

        function new();
            foreach (x_vec[i]) x_vec[i] = 0;
            foreach (coefs[i]) coefs[i] = 0;
            order_sel = SSS_ORDER_RST;
        endfunction

        function void set_order(logic [2:0] v);
            order_sel = v;
        endfunction

        function int pending();
            return expected_y.size();
        endfunction

        // Saturate to [lo, hi] and raise the clip flag when a bound is exceeded.
        function longint clamp(longint v, longint lo, longint hi, inout bit flag);
            if (v < lo) begin
                flag = 1'b1;
                return lo;
            end
            if (v > hi) begin
                flag = 1'b1;
                return hi;
            end
            return v;
        endfunction

        // Apply one accepted input transfer; a sample queues its expected output.
        function void note_transfer(logic [1:0] op, logic signed [15:0] u_in,
                                    logic [7:0] idx, logic signed [17:0] val);
            longint u, acc, s;
            int     next_x [NX];
            int     n;
            bit     clipped;
            y_exp_t e;
            if (op == SSS_OP_COEF) begin
                if (idx < NCOEF) begin
                    coefs[idx] = int'(val);
                    n_coefs++;
                    n_applied++;
                end else begin
                    n_ignored++;
                end
            end else if (op == SSS_OP_CLEAR) begin
                foreach (x_vec[i]) x_vec[i] = 0;
                n_clears++;
                n_applied++;
            end else if (op == SSS_OP_SAMPLE) begin
                n = int'(order_sel);
                if (n < 1) n = 1;
                if (n > NX) n = NX;
                clipped = 1'b0;
                u = longint'(u_in) * 256;
                // Output from the old state.
                acc = longint'(coefs[D_SLOT]) * u;
                for (int i = 0; i < n; i++)
                    acc += longint'(coefs[C_BASE + i]) * longint'(x_vec[i]);
                acc = (acc + (longint'(1) << (Y_SHIFT - 1))) >>> Y_SHIFT;
                acc = clamp(acc, -32768, 32767, clipped);
                // Next state, every row from the old vector.
                for (int i = 0; i < n; i++) begin
                    s = longint'(coefs[B_BASE + i]) * u;
                    for (int j = 0; j < n; j++)
                        s += longint'(coefs[i * NX + j]) * longint'(x_vec[j]);
                    s = (s + (longint'(1) << (X_SHIFT - 1))) >>> X_SHIFT;
                    next_x[i] = int'(clamp(s, -64'sd2147483648, 64'sd2147483647, clipped));
                end
                for (int i = 0; i < n; i++)
                    x_vec[i] = next_x[i];
                e.y   = acc[15:0];
                e.sat = clipped;
                expected_y.push_back(e);
                n_samples++;
                n_applied++;
            end else begin
                n_ignored++;
            end
        endfunction

        // Compare one accepted output transfer with the oldest prediction.
        function void check_output(logic [15:0] y, logic sat);
            y_exp_t e;
            if (expected_y.size() == 0) begin
                $error("unexpected output transfer: sample_out %0d saturated %0b",
                       $signed(y), sat);
                errors++;
                return;
            end
            e = expected_y.pop_front();
            n_results++;
            if (sat) n_clipped++;
            if (y !== e.y) begin
                $error("sample_out: expected %0d, actual %0d", $signed(e.y), $signed(y));
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0b, actual %0b", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] sample_in, [23:16] coef_index, [41:24] coef_value, [47:42] zero
    logic [47:0] s_axis_tdata  = '0;
    // [1:0] op
    logic [1:0]  s_axis_tuser  = SSS_OP_SAMPLE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // [15:0] sample_out
    logic [15:0] m_axis_tdata;
    // [0] saturated
    logic [0:0]  m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [SSS_PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int n_orders = 0;

    ss_tracker book = new();

    state_space_system_step i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Output side: check each transfer, then stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            book.check_output(m_axis_tdata, m_axis_tuser[0]);
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one input transfer, with an optional random gap before it.
    // Valid stays high after acceptance so back-to-back transfers need no toggle.
    task automatic push_item(input logic [1:0] op, input logic [15:0] smp,
                             input logic [7:0] idx, input logic [17:0] val);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, val, idx, smp};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        book.note_transfer(op, smp, idx, val);
    endtask

    // Stop offering input and wait until the block has gone quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the order register, then read it back.
    task automatic write_order(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {SSS_REG_ORDER, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        book.set_order(value[2:0]);
        n_orders++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[2:0] !== value[2:0]) begin
            $error("order readback: expected %0d, actual %0d", value[2:0], prdata[2:0]);
            book.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random transfer: mostly samples and in-range coefficient loads with
    // small values, plus clears, full-range values, stray indices and unused ops.
    task automatic random_item();
        int          r, v;
        logic [1:0]  op;
        logic [15:0] smp;
        logic [7:0]  idx;
        logic [17:0] val;
        r = $urandom_range(99);
        if (r < 55)      op = SSS_OP_SAMPLE;
        else if (r < 88) op = SSS_OP_COEF;
        else if (r < 95) op = SSS_OP_CLEAR;
        else             op = OP_UNUSED;
        if ($urandom_range(1) == 0) begin
            smp = 16'($urandom);
        end else begin
            v   = int'($urandom_range(4000)) - 2000;
            smp = v[15:0];
        end
        if ($urandom_range(9) == 0)
            idx = 8'($urandom_range(255, ss_tracker::NCOEF));
        else
            idx = 8'($urandom_range(ss_tracker::NCOEF - 1));
        if ($urandom_range(7) == 0) begin
            val = 18'($urandom);
        end else begin
            v   = int'($urandom_range(16383)) - 8192;
            val = v[17:0];
        end
        push_item(op, smp, idx, val);
    endtask

    // Main sequence.
    initial begin
        int         start;
        logic [2:0] ord;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset order of one.
        push_item(SSS_OP_SAMPLE, 16'd0, 8'd0, 18'd0);
        push_item(SSS_OP_COEF, 16'd0, 8'(ss_tracker::D_SLOT), COEF_MAX);
        push_item(SSS_OP_SAMPLE, U_MAX, 8'd0, 18'd0);
        push_item(SSS_OP_SAMPLE, U_MIN, 8'd0, 18'd0);
        push_item(SSS_OP_COEF, 16'd0, 8'(ss_tracker::B_BASE), COEF_MAX);
        push_item(SSS_OP_COEF, 16'd0, 8'd0, COEF_MIN);
        push_item(SSS_OP_SAMPLE, U_MAX, 8'd0, 18'd0);
        push_item(SSS_OP_SAMPLE, U_MIN, 8'd0, 18'd0);
        // Writes past the last slot and an unused op change nothing; a clear follows.
        push_item(SSS_OP_COEF, 16'd0, 8'(ss_tracker::NCOEF), 18'd5);
        push_item(SSS_OP_COEF, 16'hFFFF, 8'hFF, 18'h3FFFF);
        push_item(OP_UNUSED, 16'hFFFF, 8'hFF, 18'h3FFFF);
        push_item(SSS_OP_CLEAR, 16'd0, 8'd0, 18'd0);
        // Small inputs with a unit feedthrough coefficient.
        push_item(SSS_OP_COEF, 16'd0, 8'(ss_tracker::C_BASE), COEF_MIN);
        push_item(SSS_OP_COEF, 16'd0, 8'(ss_tracker::D_SLOT), COEF_ONE);
        push_item(SSS_OP_SAMPLE, 16'd1, 8'd0, 18'd0);
        push_item(SSS_OP_SAMPLE, 16'hFFFF, 8'd0, 18'd0);
        // Unstable pole: the state runs into its 32-bit limit.
        push_item(SSS_OP_COEF, 16'd0, 8'd0, COEF_MAX);
        repeat (4) push_item(SSS_OP_SAMPLE, U_MAX, 8'd0, 18'd0);
        push_item(SSS_OP_CLEAR, 16'd0, 8'd0, 18'd0);
        push_item(SSS_OP_SAMPLE, U_MIN, 8'd0, 18'd0);

        // Random phases, each with a planned order and one of four idling patterns.
        for (int p = 0; p < $size(ORDER_PLAN); p++) begin
            settle();
            ord = 3'(ORDER_PLAN[p]);
            write_order({29'($urandom), ord});
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default: begin
                    idle_pct  = 26;
                    stall_pct = 26;
                end
            endcase
            start = book.n_applied;
            while (book.n_applied - start < PHASE_ITEMS)
                random_item();
        end

        settle();
        $display("Covered %0d samples, %0d coefficient loads, %0d clears and %0d ignored transfers",
                 book.n_samples, book.n_coefs, book.n_clears, book.n_ignored);
        $display("across %0d order writes; %0d outputs checked, %0d of them saturated.",
                 n_orders, book.n_results, book.n_clipped);
        if (book.errors == 0 && book.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/sss_pkg.sv
design/sss_seq.sv
design/sss_mac.sv
design/state_space_system_step.sv
tb/tb.sv
